/* hw/rtl/psb_pkg.sv */
package psb_pkg;

	// default fraction bits of the fixed-point format
	localparam int FRAC_BITS = 16;

	// quotient bits resolved by the divider, one per stage
	localparam int DIV_STEPS = 32;

	// number of axes handled in parallel
	localparam int AXES = 3;

	// one axis of a particle
	typedef struct packed {
		logic signed [31:0] p;
		logic signed [31:0] v;
		logic signed [31:0] a;
	} psb_axis_t;

	// divider state of one axis
	typedef struct packed {
		logic        turn;
		logic        over;
		logic [31:0] amag;
		logic [31:0] rem;
		logic [31:0] num;
		logic [31:0] quo;
	} psb_div_t;

	// one restoring division step: bring in the next numerator bit
	function automatic psb_div_t dv_step(input psb_div_t d);
		psb_div_t   r;
		logic [32:0] trial;
		r     = d;
		trial = {d.rem, d.num[31]};
		r.num = {d.num[30:0], 1'b0};
		if (trial >= {1'b0, d.amag}) begin
			r.rem = 32'(trial - {1'b0, d.amag});
			r.quo = {d.quo[30:0], 1'b1};
		end else begin
			r.rem = trial[31:0];
			r.quo = {d.quo[30:0], 1'b0};
		end
		return r;
	endfunction

endpackage

/* hw/rtl/particle_swept_box.sv */
// particle_swept_box: box swept by a particle under constant acceleration
//
// slave channel s_*: one particle per transfer (position, velocity and
// acceleration per axis, duration T). master channel m_*: one box per
// transfer (min and max per axis, saturated to the signed 32-bit range).
// the turning time -v/a per axis comes from a restoring divider that
// resolves one quotient bit per stage, followed by the multiply and
// accumulate stages for the end point and the turning point.
// throughput: one particle per cycle; every stage advances each cycle
// in which the output register is empty or its transfer completes.
// when the receiver stalls, the whole pipeline holds and s_tready drops;
// nothing is lost or repeated.
// reset clears all valid bits; the first input can be taken right after.
module particle_swept_box #(
	parameter int FRAC_BITS = psb_pkg::FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, duration
	input  logic [319:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z
	output logic [191:0] m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready
);

	localparam int F    = FRAC_BITS;
	localparam int NST  = psb_pkg::DIV_STEPS;
	localparam int NAX  = psb_pkg::AXES;
	localparam int HW   = 63 - F;        // width of t*t/2^(F+1)
	localparam int HHW  = HW - 32;       // upper part of h
	localparam int APW  = 96 - F;        // width of a*h
	localparam int SW   = APW - F + 2;   // width of the point sum

	logic en;

	// stage 1: input register
	logic                 vld_s1;
	psb_pkg::psb_axis_t   ax_s1 [NAX];
	logic [31:0]          dur_s1;

	// divider stages
	logic                 vld_sd [NST+1];
	psb_pkg::psb_axis_t   ax_sd  [NST+1][NAX];
	logic [31:0]          dur_sd [NST+1];
	psb_pkg::psb_div_t    dv_sd  [NST+1][NAX];

	// stage 3: turning time
	logic                 vld_s3;
	psb_pkg::psb_axis_t   ax_s3 [NAX];
	logic [31:0]          dur_s3;
	logic [31:0]          t_s3  [NAX];

	// stage 4: first products
	logic                 vld_s4;
	logic signed [31:0]   p_s4   [NAX];
	logic signed [31:0]   a_s4   [NAX];
	logic [63:0]          tte_s4;
	logic [63:0]          ttt_s4 [NAX];
	logic signed [64:0]   vte_s4 [NAX];
	logic signed [64:0]   vtt_s4 [NAX];

	// stage 5: acceleration products
	logic                 vld_s5;
	logic signed [31:0]   p_s5    [NAX];
	logic signed [64:0]   vte_s5  [NAX];
	logic signed [64:0]   vtt_s5  [NAX];
	logic signed [64:0]   alle_s5 [NAX];
	logic signed [64:0]   allt_s5 [NAX];
	logic signed [HHW+32:0] ahie_s5 [NAX];
	logic signed [HHW+32:0] ahit_s5 [NAX];

	// stage 6: saturated points
	logic                 vld_s6;
	logic signed [31:0]   p_s6  [NAX];
	logic signed [31:0]   pe_s6 [NAX];
	logic signed [31:0]   pt_s6 [NAX];

	// output register
	logic signed [31:0]   min_q [NAX];
	logic signed [31:0]   max_q [NAX];
	logic                 vld_q;

	assign en       = !vld_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q;

	// saturate a wide point sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] s);
		if (s[SW-1:31] == '0 || s[SW-1:31] == '1) begin
			return s[31:0];
		end
		return s[SW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k <= NST; k++) vld_sd[k] <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_sd[0] <= vld_s1;
			for (int k = 0; k < NST; k++) vld_sd[k+1] <= vld_sd[k];
			vld_s3 <= vld_sd[NST];
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_q  <= vld_s6;
		end
	end

	// stage 1: unpack input
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				ax_s1[i].p <= s_tdata[32*i +: 32];
				ax_s1[i].v <= s_tdata[32*(3+i) +: 32];
				ax_s1[i].a <= s_tdata[32*(6+i) +: 32];
			end
			dur_s1 <= s_tdata[288 +: 32];
		end
	end

	// divider: setup (magnitudes, sign test, quotient overflow test),
	// then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				logic [31:0] vm;
				logic [31:0] am;
				vm = ax_s1[i].v[31] ? 32'(-ax_s1[i].v) : ax_s1[i].v;
				am = ax_s1[i].a[31] ? 32'(-ax_s1[i].a) : ax_s1[i].a;
				dv_sd[0][i].turn <= (ax_s1[i].a != '0) && (ax_s1[i].v != '0)
					&& (ax_s1[i].v[31] != ax_s1[i].a[31]);
				dv_sd[0][i].over <= (vm >> (32 - F)) >= am;
				dv_sd[0][i].amag <= am;
				dv_sd[0][i].rem  <= vm >> (32 - F);
				dv_sd[0][i].num  <= vm << F;
				dv_sd[0][i].quo  <= '0;
				ax_sd[0][i]      <= ax_s1[i];
			end
			dur_sd[0] <= dur_s1;
			for (int k = 0; k < NST; k++) begin
				for (int i = 0; i < NAX; i++) begin
					dv_sd[k+1][i] <= psb_pkg::dv_step(dv_sd[k][i]);
					ax_sd[k+1][i] <= ax_sd[k][i];
				end
				dur_sd[k+1] <= dur_sd[k];
			end
		end
	end

	// stage 3: clamp turning time to [0, T]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				if (!dv_sd[NST][i].turn) begin
					t_s3[i] <= '0;
				end else if (dv_sd[NST][i].over || dv_sd[NST][i].quo > dur_sd[NST]) begin
					t_s3[i] <= dur_sd[NST];
				end else begin
					t_s3[i] <= dv_sd[NST][i].quo;
				end
				ax_s3[i] <= ax_sd[NST][i];
			end
			dur_s3 <= dur_sd[NST];
		end
	end

	// stage 4: squares and velocity terms
	always_ff @(posedge clk) begin
		if (en) begin
			tte_s4 <= 64'(dur_s3) * 64'(dur_s3);
			for (int i = 0; i < NAX; i++) begin
				ttt_s4[i] <= 64'(t_s3[i]) * 64'(t_s3[i]);
				vte_s4[i] <= ax_s3[i].v * $signed({1'b0, dur_s3});
				vtt_s4[i] <= ax_s3[i].v * $signed({1'b0, t_s3[i]});
				p_s4[i]   <= ax_s3[i].p;
				a_s4[i]   <= ax_s3[i].a;
			end
		end
	end

	// stage 5: acceleration times half square, split in two products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				logic [HW-1:0] he;
				logic [HW-1:0] ht;
				he = HW'(tte_s4 >> (F + 1));
				ht = HW'(ttt_s4[i] >> (F + 1));
				alle_s5[i] <= a_s4[i] * $signed({1'b0, he[31:0]});
				allt_s5[i] <= a_s4[i] * $signed({1'b0, ht[31:0]});
				ahie_s5[i] <= a_s4[i] * $signed({1'b0, he[HW-1:32]});
				ahit_s5[i] <= a_s4[i] * $signed({1'b0, ht[HW-1:32]});
				vte_s5[i]  <= vte_s4[i];
				vtt_s5[i]  <= vtt_s4[i];
				p_s5[i]    <= p_s4[i];
			end
		end
	end

	// stage 6: point sums with saturation
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				logic signed [APW-1:0] ape;
				logic signed [APW-1:0] apt;
				logic signed [SW-1:0]  se;
				logic signed [SW-1:0]  st;
				ape = {ahie_s5[i], 32'b0} + APW'(alle_s5[i]);
				apt = {ahit_s5[i], 32'b0} + APW'(allt_s5[i]);
				se  = SW'(p_s5[i]) + SW'(vte_s5[i] >>> F) + SW'(ape >>> F);
				st  = SW'(p_s5[i]) + SW'(vtt_s5[i] >>> F) + SW'(apt >>> F);
				pe_s6[i] <= sat32(se);
				pt_s6[i] <= sat32(st);
				p_s6[i]  <= p_s5[i];
			end
		end
	end

	// output register: min and max of the three points
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NAX; i++) begin
				logic signed [31:0] lo;
				logic signed [31:0] hi;
				lo = p_s6[i];
				hi = p_s6[i];
				if (pe_s6[i] < lo) lo = pe_s6[i];
				if (pe_s6[i] > hi) hi = pe_s6[i];
				if (pt_s6[i] < lo) lo = pt_s6[i];
				if (pt_s6[i] > hi) hi = pt_s6[i];
				min_q[i] <= lo;
				max_q[i] <= hi;
			end
		end
	end

	// pack result
	always_comb begin
		for (int i = 0; i < NAX; i++) begin
			m_tdata[32*i +: 32]     = min_q[i];
			m_tdata[32*(3+i) +: 32] = max_q[i];
		end
	end

	// the pipeline takes input exactly when it can advance
	a_ready_en: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("s_tready does not follow pipeline enable");

	// box is never inverted on any axis
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:0]) <= $signed(m_tdata[127:96]))
			&& ($signed(m_tdata[63:32]) <= $signed(m_tdata[159:128]))
			&& ($signed(m_tdata[95:64]) <= $signed(m_tdata[191:160])))
		else $error("box minimum above maximum");

	// clamped turning time never passes the duration
	a_turn_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (t_s3[0] <= dur_s3) && (t_s3[1] <= dur_s3) && (t_s3[2] <= dur_s3))
		else $error("turning time beyond duration");

	// divider remainder stays below the divisor for a real division
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_sd[NST] && dv_sd[NST][0].turn && !dv_sd[NST][0].over)
			|-> (dv_sd[NST][0].rem < dv_sd[NST][0].amag))
		else $error("divider remainder out of range");

endmodule
